### sv/vadsr_pkg.sv
// Package for the voice allocator with ADSR envelopes.
// Holds codes, widths, the voice memory word type and the register defaults.
// No dependencies.
package vadsr_pkg;

  localparam int ENV_W = 25;
  localparam int AGE_W = 32;
  localparam int MAX_VOICES = 64;

  localparam logic [ENV_W-1:0] ONE_Q24 = 25'd16777216;
  localparam logic [ENV_W-1:0] FLOOR_Q24 = 25'd1677;

  localparam logic [ENV_W-1:0] ATTACK_RST = 25'd1024;
  localparam logic [ENV_W-1:0] DECAY_RST = 25'd16;
  localparam logic [ENV_W-1:0] SUSTAIN_RST = 25'd11744051;
  localparam logic [ENV_W-1:0] RECIP_RST = 25'd64;

  localparam int NUM_VOICES_DEF = 16;

  // Input function codes.
  localparam logic [2:0] FN_TICK = 3'd0;
  localparam logic [2:0] FN_NOTE_ON = 3'd1;
  localparam logic [2:0] FN_NOTE_OFF = 3'd2;
  localparam logic [2:0] FN_PEDAL = 3'd3;
  localparam logic [2:0] FN_PANIC = 3'd4;

  // Envelope stage codes.
  localparam logic [2:0] ST_OFF = 3'd0;
  localparam logic [2:0] ST_ATTACK = 3'd1;
  localparam logic [2:0] ST_DECAY = 3'd2;
  localparam logic [2:0] ST_SUSTAIN = 3'd3;
  localparam logic [2:0] ST_RELEASE = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_ATTACK = 3'd0;
  localparam logic [2:0] REG_DECAY = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_RECIP = 3'd3;

  // One voice as stored in the voice memory.
  typedef struct packed {
    logic             key_down;
    logic [2:0]       stage;
    logic [6:0]       pitch;
    logic [6:0]       velocity;
    logic [ENV_W-1:0] envelope;
    logic [ENV_W-1:0] rel_step;
    logic [AGE_W-1:0] age;
  } voice_t;

endpackage

### sv/vadsr_voice_mem.sv
// Voice state memory: one write port, one read port, registered read data.
// Depends on vadsr_pkg for voice_t.
module vadsr_voice_mem import vadsr_pkg::*; #(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(NUM_VOICES)-1:0] waddr,
  input  voice_t                        wdata,
  input  logic                          re,
  input  logic [$clog2(NUM_VOICES)-1:0] raddr,
  output voice_t                        rdata
);

  voice_t mem [NUM_VOICES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/voice_allocator_adsr.sv
// Polyphonic voice allocator with ADSR envelopes and sustain pedal.
// A note on with a free voice goes through the allocation state to its word; a tick
// walks all voices, one voice read per cycle unless the result channel stalls.
// Note on with stealing, note off and pedal release first sweep all voices.
// Throughput is one input word at a time, set by the sweep over the voice memory.
// Reset clears active bits, pedal, age counter and registers; memory needs no clear.
module voice_allocator_adsr import vadsr_pkg::*; #(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_func,
  input  logic [6:0]       in_pitch,
  input  logic [6:0]       in_velocity,
  input  logic             in_pedal_down,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [5:0]       out_voice_index,
  output logic             out_active,
  output logic [2:0]       out_stage,
  output logic [ENV_W-1:0] out_envelope,
  output logic [6:0]       out_note,
  output logic [6:0]       out_note_velocity,
  output logic             out_stolen,
  output logic [6:0]       out_released_count,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [ENV_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_VOICES);
  localparam int CNT_W = $clog2(NUM_VOICES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_ALLOC = 4'b0100,
    S_SUM   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ENV_W-1:0] atk_r, dec_r, sus_r, recip_r;
  logic [NUM_VOICES-1:0] active_r, active_nxt;
  logic pedal_r, pedal_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;

  logic [2:0] func_r, func_nxt;
  logic [6:0] pitch_r, pitch_nxt;
  logic [6:0] vel_r, vel_nxt;

  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [6:0] rel_cnt_r, rel_cnt_nxt;

  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic stolen_r, stolen_nxt;
  logic best_rel_r, best_rel_nxt;
  logic [ENV_W-1:0] best_env_r, best_env_nxt;
  logic [AGE_W-1:0] best_age_r, best_age_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [5:0] o_idx_r, o_idx_nxt;
  logic o_act_r, o_act_nxt;
  logic [2:0] o_stg_r, o_stg_nxt;
  logic [ENV_W-1:0] o_env_r, o_env_nxt;
  logic [6:0] o_note_r, o_note_nxt;
  logic [6:0] o_vel_r, o_vel_nxt;
  logic o_stolen_r, o_stolen_nxt;
  logic [6:0] o_rel_r, o_rel_nxt;
  logic o_last_r, o_last_nxt;

  logic mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  voice_t mem_wdata, mem_rdata;

  logic in_acc, out_free;
  logic any_free;
  logic [IDX_W-1:0] free_idx;
  logic [ENV_W-1:0] sus_eff;
  logic [49:0] prod;
  logic [ENV_W-1:0] rel_step;
  voice_t ent, ent_tick;
  logic tick_keep;
  logic cand_better;
  logic higher_active;

  vadsr_voice_mem #(.NUM_VOICES(NUM_VOICES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_r <= ATTACK_RST;
      dec_r <= DECAY_RST;
      sus_r <= SUSTAIN_RST;
      recip_r <= RECIP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTACK:  atk_r <= cfg_data;
        REG_DECAY:   dec_r <= cfg_data;
        REG_SUSTAIN: sus_r <= cfg_data;
        REG_RECIP:   recip_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lowest free voice.
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign sus_eff = (sus_r > ONE_Q24) ? ONE_Q24 : sus_r;

  // Release step from the current envelope, never zero.
  assign ent = mem_rdata;
  assign prod = 50'(ent.envelope) * 50'(recip_r);
  assign rel_step = (prod[49:24] == '0) ? ENV_W'(1) : prod[48:24];

  // Envelope advance for one voice on a tick.
  always_comb begin
    logic [ENV_W:0] sum;
    ent_tick = ent;
    tick_keep = 1'b1;
    sum = {1'b0, ent.envelope} + {1'b0, atk_r};
    case (ent.stage)
      ST_ATTACK: begin
        if (sum >= {1'b0, ONE_Q24}) begin
          ent_tick.envelope = ONE_Q24;
          ent_tick.stage = ST_DECAY;
        end else begin
          ent_tick.envelope = sum[ENV_W-1:0];
        end
      end
      ST_DECAY: begin
        if (ent.envelope < dec_r || (ent.envelope - dec_r) <= sus_eff) begin
          ent_tick.envelope = sus_eff;
          ent_tick.stage = ST_SUSTAIN;
        end else begin
          ent_tick.envelope = ent.envelope - dec_r;
        end
      end
      ST_SUSTAIN: ent_tick.envelope = sus_eff;
      ST_RELEASE: begin
        if (ent.envelope < ent.rel_step ||
            (ent.envelope - ent.rel_step) <= FLOOR_Q24) begin
          tick_keep = 1'b0;
        end else begin
          ent_tick.envelope = ent.envelope - ent.rel_step;
        end
      end
      default: tick_keep = 1'b0;
    endcase
  end

  // Steal ordering: release first, then lower envelope, then lower age.
  always_comb begin
    logic vr;
    vr = (ent.stage == ST_RELEASE);
    if (vr != best_rel_r) begin
      cand_better = vr;
    end else if (ent.envelope != best_env_r) begin
      cand_better = ent.envelope < best_env_r;
    end else begin
      cand_better = ent.age < best_age_r;
    end
  end

  assign higher_active = |((active_r >> pidx_r) >> 1);

  // Sequencer.
  always_comb begin
    logic stall;
    logic emit_tick;
    state_nxt = state_r;
    active_nxt = active_r;
    pedal_nxt = pedal_r;
    age_nxt = age_r;
    func_nxt = func_r;
    pitch_nxt = pitch_r;
    vel_nxt = vel_r;
    rd_cnt_nxt = rd_cnt_r;
    pv_nxt = pv_r;
    pidx_nxt = pidx_r;
    rel_cnt_nxt = rel_cnt_r;
    pick_nxt = pick_r;
    stolen_nxt = stolen_r;
    best_rel_nxt = best_rel_r;
    best_env_nxt = best_env_r;
    best_age_nxt = best_age_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_idx_nxt = o_idx_r;
    o_act_nxt = o_act_r;
    o_stg_nxt = o_stg_r;
    o_env_nxt = o_env_r;
    o_note_nxt = o_note_r;
    o_vel_nxt = o_vel_r;
    o_stolen_nxt = o_stolen_r;
    o_rel_nxt = o_rel_r;
    o_last_nxt = o_last_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = pidx_r;
    mem_wdata = ent;
    stall = 1'b0;
    emit_tick = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_func;
          pitch_nxt = in_pitch;
          vel_nxt = in_velocity;
          rd_cnt_nxt = '0;
          pv_nxt = 1'b0;
          rel_cnt_nxt = '0;
          stolen_nxt = 1'b0;
          case (in_func)
            FN_TICK: begin
              if (active_r != '0) state_nxt = S_SWEEP;
            end
            FN_NOTE_ON: begin
              if (any_free) begin
                pick_nxt = free_idx;
                state_nxt = S_ALLOC;
              end else begin
                stolen_nxt = 1'b1;
                state_nxt = S_SWEEP;
              end
            end
            FN_NOTE_OFF: state_nxt = S_SWEEP;
            FN_PEDAL: begin
              pedal_nxt = in_pedal_down;
              if (pedal_r != in_pedal_down && !in_pedal_down) begin
                state_nxt = S_SWEEP;
              end else begin
                state_nxt = S_SUM;
              end
            end
            FN_PANIC: begin
              active_nxt = '0;
              pedal_nxt = 1'b0;
              state_nxt = S_SUM;
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        emit_tick = pv_r && (func_r == FN_TICK) && active_r[pidx_r];
        stall = emit_tick && !out_free;
        if (!stall) begin
          // Process the voice whose word arrived this cycle.
          if (pv_r && active_r[pidx_r]) begin
            case (func_r)
              FN_TICK: begin
                mem_we = 1'b1;
                mem_wdata = ent_tick;
                out_valid_nxt = 1'b1;
                o_idx_nxt = 6'(pidx_r);
                o_act_nxt = tick_keep;
                o_stg_nxt = tick_keep ? ent_tick.stage : ST_OFF;
                o_env_nxt = tick_keep ? ent_tick.envelope : '0;
                o_note_nxt = tick_keep ? ent.pitch : '0;
                o_vel_nxt = tick_keep ? ent.velocity : '0;
                o_stolen_nxt = 1'b0;
                o_rel_nxt = '0;
                o_last_nxt = !higher_active;
                if (!tick_keep) active_nxt[pidx_r] = 1'b0;
              end
              FN_NOTE_ON: begin
                if (pidx_r == '0 || cand_better) begin
                  pick_nxt = pidx_r;
                  best_rel_nxt = (ent.stage == ST_RELEASE);
                  best_env_nxt = ent.envelope;
                  best_age_nxt = ent.age;
                end
              end
              FN_NOTE_OFF: begin
                if (ent.pitch == pitch_r) begin
                  mem_we = 1'b1;
                  mem_wdata.key_down = 1'b0;
                  if (!pedal_r && ent.stage != ST_RELEASE) begin
                    mem_wdata.stage = ST_RELEASE;
                    mem_wdata.rel_step = rel_step;
                    rel_cnt_nxt = rel_cnt_r + 7'd1;
                  end
                end
              end
              default: begin
                // Pedal lifted: release voices whose keys are up.
                if (!ent.key_down && ent.stage != ST_RELEASE) begin
                  mem_we = 1'b1;
                  mem_wdata.stage = ST_RELEASE;
                  mem_wdata.rel_step = rel_step;
                  rel_cnt_nxt = rel_cnt_r + 7'd1;
                end
              end
            endcase
          end
          // Issue the next read, or finish the sweep.
          if (rd_cnt_r != CNT_W'(NUM_VOICES)) begin
            mem_re = 1'b1;
            pv_nxt = 1'b1;
            pidx_nxt = rd_cnt_r[IDX_W-1:0];
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            pv_nxt = 1'b0;
            if (!pv_r) begin
              case (func_r)
                FN_TICK: state_nxt = S_IDLE;
                FN_NOTE_ON: state_nxt = S_ALLOC;
                default: state_nxt = S_SUM;
              endcase
            end
          end
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          mem_we = 1'b1;
          mem_waddr = pick_r;
          mem_wdata.key_down = 1'b1;
          mem_wdata.stage = ST_ATTACK;
          mem_wdata.pitch = pitch_r;
          mem_wdata.velocity = vel_r;
          mem_wdata.envelope = '0;
          mem_wdata.rel_step = '0;
          mem_wdata.age = age_r + AGE_W'(1);
          age_nxt = age_r + AGE_W'(1);
          active_nxt[pick_r] = 1'b1;
          out_valid_nxt = 1'b1;
          o_idx_nxt = 6'(pick_r);
          o_act_nxt = 1'b1;
          o_stg_nxt = ST_ATTACK;
          o_env_nxt = '0;
          o_note_nxt = pitch_r;
          o_vel_nxt = vel_r;
          o_stolen_nxt = stolen_r;
          o_rel_nxt = '0;
          o_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt = '0;
          o_act_nxt = 1'b0;
          o_stg_nxt = ST_OFF;
          o_env_nxt = '0;
          o_note_nxt = (func_r == FN_NOTE_OFF) ? pitch_r : '0;
          o_vel_nxt = '0;
          o_stolen_nxt = 1'b0;
          o_rel_nxt = rel_cnt_r;
          o_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      active_r <= '0;
      pedal_r <= 1'b0;
      age_r <= '0;
      pv_r <= 1'b0;
      rd_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      pedal_r <= pedal_nxt;
      age_r <= age_nxt;
      pv_r <= pv_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output word registers.
  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    pitch_r <= pitch_nxt;
    vel_r <= vel_nxt;
    pidx_r <= pidx_nxt;
    rel_cnt_r <= rel_cnt_nxt;
    pick_r <= pick_nxt;
    stolen_r <= stolen_nxt;
    best_rel_r <= best_rel_nxt;
    best_env_r <= best_env_nxt;
    best_age_r <= best_age_nxt;
    o_idx_r <= o_idx_nxt;
    o_act_r <= o_act_nxt;
    o_stg_r <= o_stg_nxt;
    o_env_r <= o_env_nxt;
    o_note_r <= o_note_nxt;
    o_vel_r <= o_vel_nxt;
    o_stolen_r <= o_stolen_nxt;
    o_rel_r <= o_rel_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_voice_index = o_idx_r;
  assign out_active = o_act_r;
  assign out_stage = o_stg_r;
  assign out_envelope = o_env_r;
  assign out_note = o_note_r;
  assign out_note_velocity = o_vel_r;
  assign out_stolen = o_stolen_r;
  assign out_released_count = o_rel_r;
  assign out_last = o_last_r;

`ifndef SYNTH
  // A voice word is only in flight during a sweep.
  a_pv_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> state_r == S_SWEEP) else $error("voice word outside sweep");

  // Panic frees every voice.
  a_panic_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == FN_PANIC) |=> active_r == '0)
    else $error("panic left a voice active");

  // An allocated voice is active once its word is sent.
  a_alloc_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && out_free) |=> active_r[$past(pick_r)])
    else $error("allocated voice not active");
`endif

endmodule

### tb/sv/voice_checker.sv
// Checker for the voice allocator: watches the input, result and register channels,
// predicts each result word and compares it field by field.
// Depends on vadsr_pkg.
`timescale 1ns / 1ps
module voice_checker import vadsr_pkg::*; #(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [2:0]       in_func,
  input  logic [6:0]       in_pitch,
  input  logic [6:0]       in_velocity,
  input  logic             in_pedal_down,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [5:0]       out_voice_index,
  input  logic             out_active,
  input  logic [2:0]       out_stage,
  input  logic [ENV_W-1:0] out_envelope,
  input  logic [6:0]       out_note,
  input  logic [6:0]       out_note_velocity,
  input  logic             out_stolen,
  input  logic [6:0]       out_released_count,
  input  logic             out_last,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [ENV_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [5:0]       voice_index;
    logic             active;
    logic [2:0]       stage;
    logic [ENV_W-1:0] envelope;
    logic [6:0]       note;
    logic [6:0]       note_velocity;
    logic             stolen;
    logic [6:0]       released_count;
    logic             last;
  } result_word_t;

  result_word_t expected_words[$];

  // Shadow of the voice table and registers.
  logic [ENV_W-1:0] attack_q, decay_q, sustain_q, recip_q;
  logic             v_on[NUM_VOICES];
  logic             v_key[NUM_VOICES];
  logic [2:0]       v_stage[NUM_VOICES];
  logic [6:0]       v_pitch[NUM_VOICES];
  logic [6:0]       v_vel[NUM_VOICES];
  logic [ENV_W-1:0] v_env[NUM_VOICES];
  logic [ENV_W-1:0] v_step[NUM_VOICES];
  logic [31:0]      v_age[NUM_VOICES];
  logic [31:0]      age_count;
  logic             pedal_held;

  assign pending_words = expected_words.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void free_voice(int v);
    v_on[v] = 0; v_key[v] = 0; v_stage[v] = ST_OFF; v_pitch[v] = 0;
    v_vel[v] = 0; v_env[v] = 0; v_step[v] = 0; v_age[v] = 0;
  endfunction

  function automatic result_word_t voice_word(int v, logic stolen);
    result_word_t w;
    w = '0;
    w.voice_index = 6'(v); w.active = v_on[v]; w.stage = v_stage[v];
    w.envelope = v_env[v]; w.note = v_pitch[v]; w.note_velocity = v_vel[v];
    w.stolen = stolen;
    return w;
  endfunction

  function automatic int start_release(int v);
    logic [63:0] step;
    if (!v_on[v] || v_stage[v] == ST_RELEASE) return 0;
    step = (64'(v_env[v]) * 64'(recip_q)) >> 24;
    if (step == 0) step = 1;
    v_step[v] = step[ENV_W-1:0];
    v_stage[v] = ST_RELEASE;
    return 1;
  endfunction

  // Moves one active voice's envelope forward by one tick.
  // Levels are kept signed so that a release step past zero compares low.
  function automatic void step_envelope(int v);
    longint lvl, sus;
    lvl = v_env[v];
    sus = (sustain_q > ONE_Q24) ? longint'(ONE_Q24) : longint'(sustain_q);
    case (v_stage[v])
      ST_ATTACK: begin
        lvl += attack_q;
        if (lvl >= longint'(ONE_Q24)) begin lvl = ONE_Q24; v_stage[v] = ST_DECAY; end
      end
      ST_DECAY: begin
        lvl -= decay_q;
        if (lvl <= sus) begin lvl = sus; v_stage[v] = ST_SUSTAIN; end
      end
      ST_SUSTAIN: lvl = sus;
      ST_RELEASE: begin
        lvl -= v_step[v];
        if (lvl <= longint'(FLOOR_Q24)) begin free_voice(v); return; end
      end
      default: begin free_voice(v); return; end
    endcase
    v_env[v] = ENV_W'(lvl);
  endfunction

  function automatic void predict_event(logic [2:0] fn, logic [6:0] pit, logic [6:0] vel,
                                        logic pdl);
    result_word_t w;
    result_word_t batch[$];
    int pick, rel;
    logic stolen, better, vr, pr;
    rel = 0;
    w = '0;
    case (fn)
      FN_TICK: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_on[v]) begin
            step_envelope(v);
            batch.push_back(voice_word(v, 1'b0));
          end
      end
      FN_NOTE_ON: begin
        pick = -1; stolen = 0;
        for (int v = 0; v < NUM_VOICES; v++)
          if (pick < 0 && !v_on[v]) pick = v;
        // Stealing order: release first, then lowest level, then oldest.
        if (pick < 0) begin
          pick = 0;
          for (int v = 1; v < NUM_VOICES; v++) begin
            vr = v_stage[v] == ST_RELEASE;
            pr = v_stage[pick] == ST_RELEASE;
            if (vr != pr) better = vr;
            else if (v_env[v] != v_env[pick]) better = v_env[v] < v_env[pick];
            else better = v_age[v] < v_age[pick];
            if (better) pick = v;
          end
          stolen = 1;
        end
        free_voice(pick);
        v_pitch[pick] = pit; v_vel[pick] = vel; v_key[pick] = 1;
        v_on[pick] = 1; v_stage[pick] = ST_ATTACK;
        age_count = age_count + 1;
        v_age[pick] = age_count;
        batch.push_back(voice_word(pick, stolen));
      end
      FN_NOTE_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_on[v] && v_pitch[v] == pit) begin
            v_key[v] = 0;
            if (!pedal_held) rel += start_release(v);
          end
        w.note = pit; w.released_count = 7'(rel);
        batch.push_back(w);
      end
      FN_PEDAL: begin
        if (pedal_held != pdl) begin
          pedal_held = pdl;
          if (!pdl)
            for (int v = 0; v < NUM_VOICES; v++)
              if (v_on[v] && !v_key[v]) rel += start_release(v);
        end
        w.released_count = 7'(rel);
        batch.push_back(w);
      end
      FN_PANIC: begin
        for (int v = 0; v < NUM_VOICES; v++) free_voice(v);
        pedal_held = 0;
        batch.push_back(w);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1;
    foreach (batch[i]) expected_words.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      attack_q <= ATTACK_RST; decay_q <= DECAY_RST;
      sustain_q <= SUSTAIN_RST; recip_q <= RECIP_RST;
      for (int v = 0; v < NUM_VOICES; v++) free_voice(v);
      age_count = 0; pedal_held = 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_ATTACK:  attack_q <= cfg_data;
          REG_DECAY:   decay_q <= cfg_data;
          REG_SUSTAIN: sustain_q <= cfg_data;
          REG_RECIP:   recip_q <= cfg_data;
          default: ;
        endcase
      if (in_valid && in_ready)
        predict_event(in_func, in_pitch, in_velocity, in_pedal_down);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, voice", out_voice_index, -1);
        end else begin
          want = expected_words.pop_front();
          if (out_voice_index !== want.voice_index)
            report_mismatch("voice_index", out_voice_index, want.voice_index);
          if (out_active !== want.active) report_mismatch("active", out_active, want.active);
          if (out_stage !== want.stage) report_mismatch("stage", out_stage, want.stage);
          if (out_envelope !== want.envelope)
            report_mismatch("envelope", out_envelope, want.envelope);
          if (out_note !== want.note) report_mismatch("note", out_note, want.note);
          if (out_note_velocity !== want.note_velocity)
            report_mismatch("note_velocity", out_note_velocity, want.note_velocity);
          if (out_stolen !== want.stolen) report_mismatch("stolen", out_stolen, want.stolen);
          if (out_released_count !== want.released_count)
            report_mismatch("released_count", out_released_count, want.released_count);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

### tb/sv/testbench.sv
// Top of the voice allocator testbench: clock, reset, register writes and
// event stimulus with random idling; the checker predicts and compares.
// Depends on vadsr_pkg, voice_allocator_adsr and voice_checker.
`timescale 1ns / 1ps
module testbench;
  import vadsr_pkg::*;

  localparam int VOICES = NUM_VOICES_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  logic             clk, rst_n;
  logic             in_valid, in_ready, in_pedal_down;
  logic [2:0]       in_func;
  logic [6:0]       in_pitch, in_velocity;
  logic             out_valid, out_ready;
  logic [5:0]       out_voice_index;
  logic             out_active, out_stolen, out_last;
  logic [2:0]       out_stage;
  logic [ENV_W-1:0] out_envelope;
  logic [6:0]       out_note, out_note_velocity, out_released_count;
  logic             cfg_valid, cfg_ready;
  logic [2:0]       cfg_index;
  logic [ENV_W-1:0] cfg_data;
  int               fail_count, pending_words;
  int               cycle_count;
  bit               quiet_phase, hold_off;
  bit               pedal_state;

  voice_allocator_adsr #(.NUM_VOICES(VOICES)) dut (.*);
  voice_checker #(.NUM_VOICES(VOICES)) checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 0;
      else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else out_ready <= 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [ENV_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Sends one event word, keeping valid high until it is taken. Valid stays
  // high after the accepting edge; the next falling edge either loads the
  // next word or drops valid for an idle gap.
  task automatic send_event(input logic [2:0] fn, input logic [6:0] pit,
                            input logic [6:0] vel, input logic pdl);
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1; in_func <= fn; in_pitch <= pit; in_velocity <= vel;
    in_pedal_down <= pdl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid after the last word, then waits for every result.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 0;
    while (pending_words != 0) @(negedge clk);
    repeat (VOICES + 10) @(negedge clk);
  endtask

  task automatic set_regs(input logic [ENV_W-1:0] a, input logic [ENV_W-1:0] d,
                          input logic [ENV_W-1:0] s, input logic [ENV_W-1:0] r);
    drain_all();
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, s);
    write_reg(REG_RECIP, r);
  endtask

  // One random event, weighted toward note traffic and ticks.
  task automatic random_event(input int pitch_span);
    int pick;
    logic [6:0] pit;
    pick = $urandom_range(0, 99);
    pit = 7'($urandom_range(0, pitch_span));
    if (pitch_span == 127 && $urandom_range(0, 1)) pit = 7'($urandom_range(0, 127));
    if (pick < 35) send_event(FN_TICK, 7'($urandom), 7'($urandom), 1'($urandom));
    else if (pick < 65) send_event(FN_NOTE_ON, pit, 7'($urandom), 1'($urandom));
    else if (pick < 85) send_event(FN_NOTE_OFF, pit, 7'($urandom), 1'($urandom));
    else if (pick < 95) begin
      pedal_state = $urandom_range(0, 1);
      send_event(FN_PEDAL, 7'($urandom), 7'($urandom), pedal_state);
    end else if (pick < 97) send_event(FN_PANIC, 7'($urandom), 7'($urandom), 0);
    else send_event(3'($urandom_range(5, 7)), 7'($urandom), 7'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_func = FN_TICK; in_pitch = 0; in_velocity = 0;
    in_pedal_down = 0; cfg_valid = 0; cfg_index = REG_ATTACK; cfg_data = '0;
    quiet_phase = 0; hold_off = 0; pedal_state = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: extremes, every function, pedal and stealing cases.
    send_event(FN_TICK, 0, 0, 0);
    send_event(FN_NOTE_ON, 7'd127, 7'd127, 0);
    send_event(FN_NOTE_ON, 7'd0, 7'd0, 1);
    send_event(FN_TICK, 7'h7f, 7'h7f, 1);
    send_event(FN_PEDAL, 0, 0, 1);
    send_event(FN_PEDAL, 0, 0, 1);
    send_event(FN_NOTE_OFF, 7'd127, 0, 0);
    send_event(FN_PEDAL, 0, 0, 0);
    send_event(FN_PEDAL, 0, 0, 0);
    send_event(FN_NOTE_OFF, 7'd0, 0, 0);
    send_event(FN_NOTE_OFF, 7'd55, 0, 0);
    send_event(3'd5, 0, 0, 0);
    send_event(3'd7, 7'h7f, 7'h7f, 1);
    for (int i = 0; i < VOICES + 2; i++)
      send_event(FN_NOTE_ON, 7'(i % 3), 7'(i), 0);
    send_event(FN_PANIC, 0, 0, 0);

    // Extreme settings: instant attack, full decay, full sustain, fastest release.
    set_regs(ONE_Q24, ONE_Q24, ONE_Q24, ONE_Q24);
    for (int i = 0; i < 60; i++) random_event(15);
    set_regs(25'h1ffffff, 0, 25'h1ffffff, 1);
    for (int i = 0; i < 40; i++) random_event(15);
    set_regs(1, 0, 0, 1);
    for (int i = 0; i < 30; i++) random_event(127);

    // Fast envelopes so voices cycle through every stage.
    set_regs(25'd3000000, 25'd2000000, 25'd6000000, 25'd4000000);
    send_event(FN_PANIC, 0, 0, 0);
    for (int i = 0; i < 20; i++) send_event(FN_NOTE_ON, 7'($urandom), 7'($urandom), 0);
    // Long receiver hold-off while events keep coming.
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 12; i++) send_event(FN_TICK, 0, 0, 0);
        @(negedge clk);
        in_valid <= 0;
      end
    join
    for (int i = 0; i < 100; i++) random_event(23);

    set_regs(ATTACK_RST, DECAY_RST, SUSTAIN_RST, RECIP_RST);
    for (int i = 0; i < 40; i++) random_event(127);
    quiet_phase = 1;
    for (int i = 0; i < 40; i++) random_event(15);

    drain_all();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
